FILE: hw/rtl/text_word_vocabulary_counter_assert.svh
// Assertion macros shared by the vocabulary counter RTL.
`ifndef TEXT_WORD_VOCABULARY_COUNTER_ASSERT_SVH
`define TEXT_WORD_VOCABULARY_COUNTER_ASSERT_SVH

// Check a property on every rising clock edge once reset has been released.
`define TWVC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define TWVC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/twvc_pkg.sv
// ----------------------------------------------------------------------------
// twvc_pkg
// Types, constants and helper functions of the word vocabulary counter.
// ----------------------------------------------------------------------------
`default_nettype none

package twvc_pkg;

    localparam int TWVC_HASH_SLOTS    = 65536;
    localparam int TWVC_VOCAB_ENTRIES = 16384;
    localparam int TWVC_WORD_BYTES    = 99;

    // width of the word_index field on the result channel
    localparam int TWVC_INDEX_W = 14;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [1:0] STATUS_FOUND = 2'd0;
    localparam logic [1:0] STATUS_ADDED = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam int MARK_LEN = 4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_LEN_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_HIT,
        S_ADD,
        S_COPY_RD,
        S_COPY_WR,
        S_OUT
    } twvc_state_t;

    // Bytes of the sentence mark "</s>".
    function automatic logic [7:0] mark_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h3C;
            2'd1:    b = 8'h2F;
            2'd2:    b = 8'h73;
            default: b = 8'h3E;
        endcase
        return b;
    endfunction

    // Hash of the sentence mark for a table of 2**hw slots.
    function automatic longint mark_hash(input int hw);
        longint h;
        longint s;
        longint mask;
        h = 0;
        mask = (longint'(1) << hw) - 1;
        for (int i = 0; i < MARK_LEN; i++) begin
            s = longint'(mark_byte(2'(i)));
            if (s >= 128) begin
                s = s - 256;
            end
            h = (h * 257 + s) & mask;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/twvc_in_if.sv
// ----------------------------------------------------------------------------
// twvc_in_if
// Byte channel into the vocabulary counter.
// ----------------------------------------------------------------------------
`default_nettype none

interface twvc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink   (input valid, input byte_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/twvc_out_if.sv
// ----------------------------------------------------------------------------
// twvc_out_if
// Result channel out of the vocabulary counter.
// ----------------------------------------------------------------------------
`default_nettype none

interface twvc_out_if;
    logic                              valid;
    logic                              ready;
    logic [twvc_pkg::TWVC_INDEX_W-1:0] word_index;
    logic [1:0]                        status;
    logic [63:0]                       word_total;
    logic                              last;

    modport source (output valid, output word_index, output status, output word_total,
                    output last, input ready);
    modport sink   (input valid, input word_index, input status, input word_total,
                    input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/twvc_ram.sv
// ----------------------------------------------------------------------------
// twvc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module twvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data between reads
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/twvc_hash.sv
// ----------------------------------------------------------------------------
// twvc_hash
// One step of the running word hash: h*257 plus the sign-extended byte.
// ----------------------------------------------------------------------------
`default_nettype none

module twvc_hash #(
    parameter int HASH_W = 16
) (
    input  wire logic [HASH_W-1:0] hash_in,
    input  wire logic [7:0]        byte_in,
    output logic      [HASH_W-1:0] hash_out
);

    logic [HASH_W+7:0] ext_byte;
    logic [HASH_W+7:0] sum;

    assign ext_byte = {{HASH_W{byte_in[7]}}, byte_in};
    // h*257 = h + (h << 8); keep the low bits only
    assign sum      = {8'd0, hash_in} + {hash_in, 8'd0} + ext_byte;
    assign hash_out = sum[HASH_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/text_word_vocabulary_counter.sv
// ----------------------------------------------------------------------------
// text_word_vocabulary_counter
// Splits a byte stream into words and counts them in a hashed vocabulary.
// ----------------------------------------------------------------------------
// Bytes arrive on in_ch one byte at a time. Space, tab and newline end a
// token; CR and zero bytes are dropped; a newline also yields "</s>", which
// is vocabulary entry 0. For each completed token one result leaves on out_ch
// (a newline after a token gives two, the second flagged last). After reset
// the block sweeps the slot table, one slot a cycle, before in_ch goes ready.
// A token end runs a single sequencer over the slot table: each occupied
// probed slot passes through slot read, slot check and length check (the
// empty slot that ends a probe through slot read and slot check only), and
// each compared byte through the one byte compare unit; a hit then updates
// the count, and a new entry copies each byte into the byte store; then the
// result waits in an output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_word_vocabulary_counter #(
    parameter int HASH_SLOTS    = twvc_pkg::TWVC_HASH_SLOTS,
    parameter int VOCAB_ENTRIES = twvc_pkg::TWVC_VOCAB_ENTRIES,
    parameter int WORD_BYTES    = twvc_pkg::TWVC_WORD_BYTES
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    twvc_in_if.sink    in_ch,
    twvc_out_if.source out_ch
);

    import twvc_pkg::*;

    `include "text_word_vocabulary_counter_assert.svh"

    localparam int HASH_W = $clog2(HASH_SLOTS);
    localparam int IDX_W  = $clog2(VOCAB_ENTRIES);
    localparam int SV_W   = $clog2(VOCAB_ENTRIES + 1);
    localparam int LEN_W  = $clog2(WORD_BYTES + 1);
    localparam int BUF_W  = $clog2(WORD_BYTES);
    localparam longint BYTES_DEPTH = longint'(VOCAB_ENTRIES) * longint'(WORD_BYTES);
    localparam int BA_W   = $clog2(BYTES_DEPTH);

    localparam logic [HASH_W-1:0] MARK_POS  = HASH_W'(mark_hash(HASH_W));
    localparam logic [HASH_W-1:0] LAST_SLOT = HASH_W'(HASH_SLOTS - 1);
    localparam logic [SV_W-1:0]   VOCAB_MAX = SV_W'(VOCAB_ENTRIES);
    localparam logic [LEN_W-1:0]  MARK_LENV = LEN_W'(MARK_LEN);
    localparam logic [LEN_W-1:0]  TOK_MAX   = LEN_W'(WORD_BYTES - 1);
    localparam logic [63:0]       TOTAL_MAX = '1;

    // ---------------- state ----------------
    twvc_state_t       state_reg, state_next;
    logic [HASH_W-1:0] clr_reg, clr_next;
    logic [SV_W-1:0]   used_reg, used_next;
    logic [LEN_W-1:0]  tok_len_reg, tok_len_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [HASH_W-1:0] pos_reg, pos_next;
    logic [HASH_W-1:0] probe_reg, probe_next;
    logic [LEN_W-1:0]  wlen_reg, wlen_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic              mark_reg, mark_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BA_W-1:0]   base_reg, base_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [63:0]       res_total_reg, res_total_next;

    // ---------------- memories ----------------
    logic              slot_we, slot_re;
    logic [HASH_W-1:0] slot_waddr, slot_raddr;
    logic [SV_W-1:0]   slot_wdata, slot_q;
    logic              bytes_we, bytes_re;
    logic [BA_W-1:0]   bytes_waddr, bytes_raddr;
    logic [7:0]        bytes_wdata, bytes_q;
    logic              len_we, len_re;
    logic [IDX_W-1:0]  len_waddr, len_raddr;
    logic [LEN_W-1:0]  len_wdata, len_q;
    logic              total_we, total_re;
    logic [IDX_W-1:0]  total_waddr, total_raddr;
    logic [63:0]       total_wdata, total_q;
    logic              tok_we, tok_re;
    logic [BUF_W-1:0]  tok_waddr, tok_raddr;
    logic [7:0]        tok_wdata, tok_q;

    twvc_ram #(.WIDTH(SV_W), .DEPTH(HASH_SLOTS)) u_slot_ram (
        .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .re(slot_re), .raddr(slot_raddr), .rdata(slot_q)
    );

    twvc_ram #(.WIDTH(8), .DEPTH(int'(BYTES_DEPTH))) u_bytes_ram (
        .clk(clk), .we(bytes_we), .waddr(bytes_waddr), .wdata(bytes_wdata),
        .re(bytes_re), .raddr(bytes_raddr), .rdata(bytes_q)
    );

    twvc_ram #(.WIDTH(LEN_W), .DEPTH(VOCAB_ENTRIES)) u_len_ram (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .re(len_re), .raddr(len_raddr), .rdata(len_q)
    );

    twvc_ram #(.WIDTH(64), .DEPTH(VOCAB_ENTRIES)) u_total_ram (
        .clk(clk), .we(total_we), .waddr(total_waddr), .wdata(total_wdata),
        .re(total_re), .raddr(total_raddr), .rdata(total_q)
    );

    twvc_ram #(.WIDTH(8), .DEPTH(WORD_BYTES)) u_tok_ram (
        .clk(clk), .we(tok_we), .waddr(tok_waddr), .wdata(tok_wdata),
        .re(tok_re), .raddr(tok_raddr), .rdata(tok_q)
    );

    // running hash step
    logic [HASH_W-1:0] hash_step;

    twvc_hash #(.HASH_W(HASH_W)) u_hash (
        .hash_in(hash_reg), .byte_in(in_ch.byte_value), .hash_out(hash_step)
    );

    // ---------------- decode ----------------
    logic       in_fire, out_fire;
    logic       is_skip, is_lf, is_sep;
    logic       slot_empty, store_room, probe_end, k_end, len_ok, byte_ok;
    logic [7:0] word_byte;
    logic [SV_W-1:0] slot_idx;

    assign in_fire    = in_ch.valid && in_ch.ready;
    assign out_fire   = out_ch.valid && out_ch.ready;
    assign is_skip    = (in_ch.byte_value == CH_CR) || (in_ch.byte_value == CH_NUL);
    assign is_lf      = (in_ch.byte_value == CH_LF);
    assign is_sep     = is_lf || (in_ch.byte_value == CH_SPACE) || (in_ch.byte_value == CH_TAB);
    assign slot_empty = (slot_q == '0);
    assign slot_idx   = slot_q - SV_W'(1);
    assign store_room = (used_reg < VOCAB_MAX);
    assign probe_end  = (probe_reg == LAST_SLOT);
    assign k_end      = (k_reg == wlen_reg - LEN_W'(1));
    assign len_ok     = (len_q == wlen_reg);
    // the mark's bytes come from constants, a token's from its buffer
    assign word_byte  = mark_reg ? mark_byte(k_reg[1:0]) : tok_q;
    assign byte_ok    = (bytes_q == word_byte);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire && !is_skip && is_sep && ((tok_len_reg != '0) || is_lf))
                begin
                    state_next = S_SLOT_RD;
                end
            end
            S_SLOT_RD:
            begin
                state_next = S_SLOT_CHK;
            end
            S_SLOT_CHK:
            begin
                if (!slot_empty)
                begin
                    state_next = S_LEN_CHK;
                end
                else if (store_room)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_LEN_CHK:
            begin
                if (len_ok)
                begin
                    state_next = S_CMP_RD;
                end
                else if (probe_end)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SLOT_RD;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (!byte_ok)
                begin
                    state_next = probe_end ? S_OUT : S_SLOT_RD;
                end
                else if (k_end)
                begin
                    state_next = S_HIT;
                end
                else
                begin
                    state_next = S_CMP_RD;
                end
            end
            S_HIT:
            begin
                state_next = S_OUT;
            end
            S_ADD:
            begin
                state_next = S_COPY_RD;
            end
            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                state_next = k_end ? S_OUT : S_COPY_RD;
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    state_next = pend_reg ? S_SLOT_RD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb
    begin
        logic [63:0] bumped;
        logic        miss;

        clr_next        = clr_reg;
        used_next       = used_reg;
        tok_len_next    = tok_len_reg;
        hash_next       = hash_reg;
        pos_next        = pos_reg;
        probe_next      = probe_reg;
        wlen_next       = wlen_reg;
        k_next          = k_reg;
        mark_next       = mark_reg;
        pend_next       = pend_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;
        res_total_next  = res_total_reg;

        slot_we = 1'b0; slot_waddr = pos_reg; slot_wdata = '0;
        slot_re = 1'b0; slot_raddr = pos_reg;
        bytes_we = 1'b0; bytes_waddr = base_reg + BA_W'(k_reg); bytes_wdata = word_byte;
        bytes_re = 1'b0; bytes_raddr = base_reg + BA_W'(k_reg);
        len_we = 1'b0; len_waddr = idx_reg; len_wdata = wlen_reg;
        len_re = 1'b0; len_raddr = slot_idx[IDX_W-1:0];
        total_we = 1'b0; total_waddr = idx_reg; total_wdata = 64'd1;
        total_re = 1'b0; total_raddr = slot_idx[IDX_W-1:0];
        tok_we = 1'b0; tok_waddr = tok_len_reg[BUF_W-1:0]; tok_wdata = in_ch.byte_value;
        tok_re = 1'b0; tok_raddr = k_reg[BUF_W-1:0];

        bumped = (total_q == TOTAL_MAX) ? total_q : total_q + 64'd1;
        miss   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // sweep the slot table; seed entry 0 with the mark
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = (clr_reg == MARK_POS) ? SV_W'(1) : '0;
                if (clr_reg < HASH_W'(MARK_LEN))
                begin
                    bytes_we    = 1'b1;
                    bytes_waddr = BA_W'(clr_reg);
                    bytes_wdata = mark_byte(clr_reg[1:0]);
                end
                if (clr_reg == '0)
                begin
                    len_we      = 1'b1;
                    len_waddr   = '0;
                    len_wdata   = MARK_LENV;
                    total_we    = 1'b1;
                    total_waddr = '0;
                    total_wdata = 64'd0;
                end
                clr_next = clr_reg + HASH_W'(1);
            end
            S_IDLE:
            begin
                if (in_fire && !is_skip)
                begin
                    if (is_sep)
                    begin
                        probe_next = '0;
                        if (tok_len_reg != '0)
                        begin
                            mark_next    = 1'b0;
                            wlen_next    = tok_len_reg;
                            pos_next     = hash_reg;
                            pend_next    = is_lf;
                            tok_len_next = '0;
                            hash_next    = '0;
                        end
                        else if (is_lf)
                        begin
                            mark_next = 1'b1;
                            wlen_next = MARK_LENV;
                            pos_next  = MARK_POS;
                            pend_next = 1'b0;
                        end
                    end
                    else if (tok_len_reg < TOK_MAX)
                    begin
                        tok_we       = 1'b1;
                        tok_len_next = tok_len_reg + LEN_W'(1);
                        hash_next    = hash_step;
                    end
                end
            end
            S_SLOT_RD:
            begin
                slot_re = 1'b1;
            end
            S_SLOT_CHK:
            begin
                if (!slot_empty)
                begin
                    len_re    = 1'b1;
                    total_re  = 1'b1;
                    idx_next  = slot_idx[IDX_W-1:0];
                    base_next = BA_W'(slot_idx[IDX_W-1:0] * BA_W'(WORD_BYTES));
                end
                else if (!store_room)
                begin
                    res_idx_next    = '0;
                    res_status_next = STATUS_FULL;
                    res_total_next  = '0;
                end
            end
            S_LEN_CHK:
            begin
                k_next = '0;
                miss   = !len_ok;
            end
            S_CMP_RD:
            begin
                bytes_re = 1'b1;
                tok_re   = 1'b1;
            end
            S_CMP_CHK:
            begin
                miss = !byte_ok;
                if (byte_ok && !k_end)
                begin
                    k_next = k_reg + LEN_W'(1);
                end
            end
            S_HIT:
            begin
                total_we        = 1'b1;
                total_wdata     = bumped;
                res_idx_next    = idx_reg;
                res_status_next = STATUS_FOUND;
                res_total_next  = bumped;
            end
            S_ADD:
            begin
                slot_we     = 1'b1;
                slot_wdata  = used_reg + SV_W'(1);
                len_we      = 1'b1;
                len_waddr   = used_reg[IDX_W-1:0];
                total_we    = 1'b1;
                total_waddr = used_reg[IDX_W-1:0];
                idx_next    = used_reg[IDX_W-1:0];
                base_next   = BA_W'(used_reg[IDX_W-1:0] * BA_W'(WORD_BYTES));
                used_next   = used_reg + SV_W'(1);
                k_next      = '0;
            end
            S_COPY_RD:
            begin
                tok_re = 1'b1;
            end
            S_COPY_WR:
            begin
                bytes_we = 1'b1;
                if (k_end)
                begin
                    res_idx_next    = idx_reg;
                    res_status_next = STATUS_ADDED;
                    res_total_next  = 64'd1;
                end
                else
                begin
                    k_next = k_reg + LEN_W'(1);
                end
            end
            S_OUT:
            begin
                if (out_fire && pend_reg)
                begin
                    // follow the token with the sentence mark
                    mark_next  = 1'b1;
                    wlen_next  = MARK_LENV;
                    pos_next   = MARK_POS;
                    probe_next = '0;
                    pend_next  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // advance to the next slot, or give up once every slot was probed
        if (miss)
        begin
            pos_next   = pos_reg + HASH_W'(1);
            probe_next = probe_reg + HASH_W'(1);
            if (probe_end)
            begin
                res_idx_next    = '0;
                res_status_next = STATUS_FULL;
                res_total_next  = '0;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            used_reg    <= SV_W'(1);
            tok_len_reg <= '0;
            hash_reg    <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            used_reg    <= used_next;
            tok_len_reg <= tok_len_next;
            hash_reg    <= hash_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        probe_reg      <= probe_next;
        wlen_reg       <= wlen_next;
        k_reg          <= k_next;
        mark_reg       <= mark_next;
        idx_reg        <= idx_next;
        base_reg       <= base_next;
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
        res_total_reg  <= res_total_next;
    end

    // ---------------- ports ----------------
    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = (state_reg == S_OUT);
    assign out_ch.word_index = TWVC_INDEX_W'(res_idx_reg);
    assign out_ch.status     = res_status_reg;
    assign out_ch.word_total = res_total_reg;
    assign out_ch.last       = !pend_reg;

    // ---------------- assertions ----------------
    `TWVC_ASSERT(a_no_overlap, !(in_ch.ready && out_ch.valid), "byte taken while a result waits")
    `TWVC_ASSERT(a_full_zero, (out_ch.valid && out_ch.status == STATUS_FULL) |-> (out_ch.word_index == '0 && out_ch.word_total == '0), "full result not zeroed")
    `TWVC_ASSERT(a_status_code, out_ch.valid |-> (out_ch.status != 2'd3), "undefined status code")
    `TWVC_ASSERT(a_used_bound, (used_reg <= VOCAB_MAX) && (used_reg != '0), "entry count out of range")
    `TWVC_ASSERT(a_mark_last, (out_ch.valid && mark_reg) |-> out_ch.last, "sentence mark not flagged last")

endmodule

`default_nettype wire
